/* sv/bitmap_page_allocator_refcount_assert.svh */
// assertion macros for the bitmap page allocator
// expects signals named clock and reset in the including module
`ifndef BITMAP_PAGE_ALLOCATOR_REFCOUNT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_REFCOUNT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BPA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpa assertion failed");

// next-cycle implication, disabled during reset
`define BPA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpa assertion failed");

`endif

/* sv/bpa_pkg.sv */
// shared types and constants of the bitmap page allocator
// no dependencies
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int ADDR_W      = 32;
   localparam int PAGES_W     = 13;
   localparam int COUNT_W     = 8;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int CFG_REGIONS = 2;
   localparam int BM_WORD     = 8;
   localparam int BM_SHIFT    = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 3'd0,
      KIND_FREE  = 3'd1,
      KIND_INC   = 3'd2,
      KIND_DEC   = 3'd3,
      KIND_QUERY = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_NO_FREE = 3'd1,
      STATUS_STILL   = 3'd2,
      STATUS_MISALGN = 3'd3,
      STATUS_RANGE   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_REGION0_BASE  = 2'd0,
      CSR_REGION0_PAGES = 2'd1,
      CSR_REGION1_BASE  = 2'd2,
      CSR_REGION1_PAGES = 2'd3
   } csr_index_type;

endpackage

/* sv/bpa_ram.sv */
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bpa_ram #(
   parameter int DEPTH = 256,
   parameter int DW    = 8,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* sv/bitmap_page_allocator_refcount.sv */
// count ops read and update the count memory; free decrements the count and clears the bit at
//   zero; alloc scans the bitmap word by word (8 pages per word) from the hint, then wraps
// requests: one at a time, req_stall holds the next until the response is loaded
// reset: synchronous, clears config and counters, then a clearing pass zeroes both memories;
//   requests stall during the pass; config writes are taken throughout
// depends on bpa_pkg, bpa_ram and bitmap_page_allocator_refcount_assert.svh
`timescale 1ns / 1ps
`include "bitmap_page_allocator_refcount_assert.svh"

module bitmap_page_allocator_refcount #(
   parameter int PAGE_BYTES   = 4096,
   parameter int REGION_PAGES = 4096,
   parameter int TOTAL_PAGES  = 65536,
   parameter int NUM_REGIONS  = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bpa_pkg::KIND_W-1:0]           req_kind,
   input  logic [bpa_pkg::ADDR_W-1:0]           req_page_addr,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bpa_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bpa_pkg::ADDR_W-1:0]           rsp_alloc_addr,
   output logic signed [bpa_pkg::COUNT_W-1:0]   rsp_ref_count,
   // config write port
   input  logic                                 csr_wr_en,
   input  logic [1:0]                           csr_index,
   input  logic [bpa_pkg::ADDR_W-1:0]           csr_wdata
);

   // regions actually used: config only exists for two
   localparam int LIVE  = (NUM_REGIONS < bpa_pkg::CFG_REGIONS) ? NUM_REGIONS
                                                                : bpa_pkg::CFG_REGIONS;
   localparam int RW    = (LIVE > 1) ? $clog2(LIVE) : 1;
   localparam int RC_W  = $clog2(LIVE + 1);
   localparam int CNT_W = $clog2(REGION_PAGES + 1);
   localparam int PI_W  = ($clog2(REGION_PAGES) > 4) ? $clog2(REGION_PAGES) : 4;
   localparam int WI_W  = PI_W - bpa_pkg::BM_SHIFT;
   localparam int SP_W  = CNT_W + 1;
   localparam int BM_AW = RW + WI_W;
   localparam int BM_DEPTH = 1 << BM_AW;
   localparam int PB_W  = $clog2(PAGE_BYTES);
   localparam int SL_W  = $clog2(TOTAL_PAGES);
   localparam int CLR_N = (TOTAL_PAGES > BM_DEPTH) ? TOTAL_PAGES : BM_DEPTH;
   localparam int CLR_W = $clog2(CLR_N);
   localparam int AW    = bpa_pkg::ADDR_W;
   localparam int CW    = bpa_pkg::COUNT_W;
   localparam int BW    = bpa_pkg::BM_WORD;
   localparam int BS    = bpa_pkg::BM_SHIFT;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_C_RC,
      S_F_RC,
      S_F_BM,
      S_A_REG,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_A_MARK,
      S_A_WR,
      S_RESP
   } state_type;

   // which search the scan loop is running
   typedef enum logic [1:0] {
      PH_FIRST,
      PH_WRAP,
      PH_HINT
   } phase_type;

   // config registers
   logic [AW-1:0]               base_ff  [bpa_pkg::CFG_REGIONS];
   logic [bpa_pkg::PAGES_W-1:0] pages_ff [bpa_pkg::CFG_REGIONS];

   // per-region counters
   logic [CNT_W-1:0] used_ff [LIVE];
   logic [CNT_W-1:0] hint_ff [LIVE];

   // control
   state_type                    state_ff;
   phase_type                    phase_ff;
   logic [RC_W-1:0]              r_ff;
   bpa_pkg::kind_type            kind_ff;
   logic [SL_W-1:0]              slot_ff;
   logic [CNT_W-1:0]             idx_ff;
   logic [CNT_W-1:0]             start_ff;
   logic [CNT_W-1:0]             from_ff;
   logic [CNT_W-1:0]             to_ff;
   logic [SP_W-1:0]              p_ff;
   logic [CLR_W-1:0]             clr_ff;

   // pending result and output register
   bpa_pkg::status_type          res_status_ff;
   logic [AW-1:0]                res_addr_ff;
   logic [CW-1:0]                res_count_ff;
   logic                         rsp_valid_ff;
   logic [bpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [AW-1:0]                rsp_alloc_addr_ff;
   logic [CW-1:0]                rsp_ref_count_ff;

   // memory ports
   logic             bm_we;
   logic [BM_AW-1:0] bm_waddr;
   logic [BW-1:0]    bm_wdata;
   logic [BM_AW-1:0] bm_raddr;
   logic [BW-1:0]    bm_rdata;
   logic             rc_we;
   logic [SL_W-1:0]  rc_waddr;
   logic [CW-1:0]    rc_wdata;
   logic [SL_W-1:0]  rc_raddr;
   logic [CW-1:0]    rc_rdata;

   // derived values
   logic [RW-1:0]    ri;
   logic [CNT_W-1:0] effn;
   logic [CNT_W-1:0] start_pick;
   logic [AW-1:0]    req_slot;
   logic             req_slot_ok;
   logic             req_misalign;
   logic             free_found;
   logic [RW-1:0]    free_hit;
   logic [CNT_W-1:0] free_idx;
   logic [BW-1:0]    cand;
   logic             scan_any;
   logic [CNT_W-1:0] scan_pos;
   logic             scan_end;
   logic             scan_hit;
   logic [CNT_W-1:0] idx_next;
   logic [BW-1:0]    bit_mask;
   logic             bit_set;
   logic [AW-1:0]    a_addr;
   logic [AW-1:0]    a_slot;
   logic             a_slot_ok;
   logic [CW-1:0]    rc_new;

   // page count clamped to the region size
   function automatic logic [CNT_W-1:0] eff_pages(input logic [bpa_pkg::PAGES_W-1:0] n);
      logic [CNT_W-1:0] res;
      if (32'(n) > 32'(REGION_PAGES)) begin
         res = CNT_W'(REGION_PAGES);
      end else begin
         res = CNT_W'(n);
      end
      return res;
   endfunction

   assign ri         = r_ff[RW-1:0];
   assign effn       = eff_pages(pages_ff[ri]);
   // hint at or past the page count restarts the search at page 0
   assign start_pick = (hint_ff[ri] < effn) ? hint_ff[ri] : '0;

   assign req_slot     = req_page_addr >> PB_W;
   assign req_slot_ok  = req_slot < 32'(TOTAL_PAGES);
   assign req_misalign = (req_page_addr & AW'(PAGE_BYTES - 1)) != '0;

   // region lookup for free, first region in order wins
   always_comb begin
      logic [AW+1:0] lo;
      logic [AW+1:0] hi;
      free_found = 1'b0;
      free_hit   = '0;
      for (int r = LIVE - 1; r >= 0; r--) begin
         lo = (AW + 2)'(base_ff[r]);
         hi = lo + ((AW + 2)'(eff_pages(pages_ff[r])) << PB_W);
         if ((AW + 2)'(req_page_addr) >= lo && (AW + 2)'(req_page_addr) < hi) begin
            free_found = 1'b1;
            free_hit   = RW'(r);
         end
      end
   end

   assign free_idx = CNT_W'((req_page_addr - base_ff[free_hit]) >> PB_W);

   // scan loop: free pages of the current word inside [from, to)
   always_comb begin
      logic [SP_W-1:0] pb;
      cand     = '0;
      scan_pos = '0;
      for (int b = BW - 1; b >= 0; b--) begin
         pb = p_ff + SP_W'(b);
         cand[b] = !bm_rdata[b] && pb >= SP_W'(from_ff) && pb < SP_W'(to_ff);
         if (cand[b]) begin
            scan_pos = CNT_W'(pb);
         end
      end
   end

   assign scan_any = |cand;
   assign scan_end = (state_ff == S_SCAN_RD && p_ff >= SP_W'(to_ff)) ||
                     (state_ff == S_SCAN_CHK && scan_any);
   assign scan_hit = (state_ff == S_SCAN_CHK);

   assign idx_next  = idx_ff + CNT_W'(1);
   assign bit_mask  = BW'(1) << idx_ff[BS-1:0];
   assign bit_set   = (bm_rdata & bit_mask) != '0;

   // address of the page being allocated
   assign a_addr    = base_ff[ri] + (AW'(idx_ff) << PB_W);
   assign a_slot    = a_addr >> PB_W;
   assign a_slot_ok = a_slot < 32'(TOTAL_PAGES);

   always_comb begin
      unique case (kind_ff)
         bpa_pkg::KIND_INC: rc_new = rc_rdata + CW'(1);
         bpa_pkg::KIND_DEC: rc_new = rc_rdata - CW'(1);
         default:           rc_new = rc_rdata;
      endcase
   end

   // memory port steering
   always_comb begin
      bm_raddr = {ri, idx_ff[PI_W-1:BS]};
      bm_we    = 1'b0;
      bm_waddr = {ri, idx_ff[PI_W-1:BS]};
      bm_wdata = bm_rdata | bit_mask;
      rc_raddr = req_slot[SL_W-1:0];
      rc_we    = 1'b0;
      rc_waddr = slot_ff;
      rc_wdata = rc_new;
      unique case (state_ff)
         S_CLEAR: begin
            bm_we    = 32'(clr_ff) < 32'(BM_DEPTH);
            bm_waddr = clr_ff[BM_AW-1:0];
            bm_wdata = '0;
            rc_we    = 32'(clr_ff) < 32'(TOTAL_PAGES);
            rc_waddr = clr_ff[SL_W-1:0];
            rc_wdata = '0;
         end
         S_SCAN_RD: begin
            bm_raddr = {ri, p_ff[PI_W-1:BS]};
         end
         S_C_RC: begin
            rc_we = (kind_ff == bpa_pkg::KIND_INC) || (kind_ff == bpa_pkg::KIND_DEC);
         end
         S_F_RC: begin
            rc_we    = 1'b1;
            rc_wdata = rc_rdata - CW'(1);
         end
         S_F_BM: begin
            bm_we    = bit_set;
            bm_wdata = bm_rdata & ~bit_mask;
         end
         S_A_WR: begin
            bm_we    = 1'b1;
            rc_we    = a_slot_ok;
            rc_waddr = a_slot[SL_W-1:0];
            rc_wdata = CW'(1);
         end
         default: begin
         end
      endcase
   end

   // used-page bitmap, one word of pages per entry
   bpa_ram #(
      .DEPTH (BM_DEPTH),
      .DW    (BW),
      .AW    (BM_AW)
   ) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

   // per-page reference counts
   bpa_ram #(
      .DEPTH (TOTAL_PAGES),
      .DW    (CW),
      .AW    (SL_W)
   ) u_refcnt (
      .clock (clock),
      .we    (rc_we),
      .waddr (rc_waddr),
      .wdata (rc_wdata),
      .raddr (rc_raddr),
      .rdata (rc_rdata)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_alloc_addr = rsp_alloc_addr_ff;
   assign rsp_ref_count  = rsp_ref_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= PH_FIRST;
         clr_ff       <= '0;
         r_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < bpa_pkg::CFG_REGIONS; r++) begin
            base_ff[r]  <= '0;
            pages_ff[r] <= '0;
         end
         for (int r = 0; r < LIVE; r++) begin
            used_ff[r] <= '0;
            hint_ff[r] <= '0;
         end
      end else begin
         // config writes
         if (csr_wr_en) begin
            unique case (bpa_pkg::csr_index_type'(csr_index))
               bpa_pkg::CSR_REGION0_BASE:  base_ff[0]  <= csr_wdata;
               bpa_pkg::CSR_REGION0_PAGES: pages_ff[0] <= csr_wdata[bpa_pkg::PAGES_W-1:0];
               bpa_pkg::CSR_REGION1_BASE:  base_ff[1]  <= csr_wdata;
               bpa_pkg::CSR_REGION1_PAGES: pages_ff[1] <= csr_wdata[bpa_pkg::PAGES_W-1:0];
            endcase
         end

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CLR_W'(1);
               if (clr_ff == CLR_W'(CLR_N - 1)) begin
                  state_ff <= S_IDLE;
               end
            end

            S_IDLE: begin
               if (req_valid) begin
                  kind_ff      <= bpa_pkg::kind_type'(req_kind);
                  slot_ff      <= req_slot[SL_W-1:0];
                  idx_ff       <= free_idx;
                  r_ff         <= RC_W'(free_hit);
                  res_addr_ff  <= '0;
                  res_count_ff <= '0;
                  unique case (bpa_pkg::kind_type'(req_kind))
                     bpa_pkg::KIND_ALLOC: begin
                        r_ff     <= '0;
                        state_ff <= S_A_REG;
                     end
                     bpa_pkg::KIND_FREE: begin
                        priority if (req_misalign) begin
                           res_status_ff <= bpa_pkg::STATUS_MISALGN;
                           state_ff      <= S_RESP;
                        end else if (!req_slot_ok || !free_found) begin
                           res_status_ff <= bpa_pkg::STATUS_RANGE;
                           state_ff      <= S_RESP;
                        end else begin
                           state_ff <= S_F_RC;
                        end
                     end
                     bpa_pkg::KIND_INC, bpa_pkg::KIND_DEC, bpa_pkg::KIND_QUERY: begin
                        if (!req_slot_ok) begin
                           res_status_ff <= bpa_pkg::STATUS_RANGE;
                           state_ff      <= S_RESP;
                        end else begin
                           state_ff <= S_C_RC;
                        end
                     end
                     default: begin
                        // unknown kind
                        res_status_ff <= bpa_pkg::STATUS_RANGE;
                        state_ff      <= S_RESP;
                     end
                  endcase
               end
            end

            S_C_RC: begin
               res_count_ff  <= rc_new;
               res_status_ff <= bpa_pkg::STATUS_OK;
               state_ff      <= S_RESP;
            end

            S_F_RC: begin
               // single decrement, page released only at zero
               res_count_ff <= rc_rdata - CW'(1);
               if (rc_rdata != CW'(1)) begin
                  res_status_ff <= bpa_pkg::STATUS_STILL;
                  state_ff      <= S_RESP;
               end else begin
                  state_ff <= S_F_BM;
               end
            end

            S_F_BM: begin
               // bit already clear: used count stays
               if (bit_set && used_ff[ri] != '0) begin
                  used_ff[ri] <= used_ff[ri] - CNT_W'(1);
               end
               if (idx_ff < hint_ff[ri]) begin
                  hint_ff[ri] <= idx_ff;
               end
               res_status_ff <= bpa_pkg::STATUS_OK;
               state_ff      <= S_RESP;
            end

            S_A_REG: begin
               priority if (32'(r_ff) >= 32'(LIVE)) begin
                  res_status_ff <= bpa_pkg::STATUS_NO_FREE;
                  res_addr_ff   <= '1;
                  res_count_ff  <= '0;
                  state_ff      <= S_RESP;
               end else if (used_ff[ri] >= effn) begin
                  r_ff <= r_ff + RC_W'(1);
               end else begin
                  start_ff <= start_pick;
                  from_ff  <= start_pick;
                  to_ff    <= effn;
                  p_ff     <= SP_W'({start_pick[CNT_W-1:BS], BS'(0)});
                  phase_ff <= PH_FIRST;
                  state_ff <= S_SCAN_RD;
               end
            end

            S_SCAN_RD: begin
               state_ff <= S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
               if (!scan_any) begin
                  p_ff     <= p_ff + SP_W'(BW);
                  state_ff <= S_SCAN_RD;
               end
            end

            S_A_MARK: begin
               state_ff <= S_A_WR;
            end

            S_A_WR: begin
               used_ff[ri]   <= used_ff[ri] + CNT_W'(1);
               res_status_ff <= bpa_pkg::STATUS_OK;
               res_addr_ff   <= a_addr;
               res_count_ff  <= CW'(1);
               // look for the next free page above the one just taken
               from_ff  <= idx_next;
               to_ff    <= effn;
               p_ff     <= SP_W'({idx_next[CNT_W-1:BS], BS'(0)});
               phase_ff <= PH_HINT;
               state_ff <= S_SCAN_RD;
            end

            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_status_ff     <= res_status_ff;
                  rsp_alloc_addr_ff <= res_addr_ff;
                  rsp_ref_count_ff  <= res_count_ff;
                  state_ff          <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // end of a scan overrides the loop's own stepping
         if (scan_end) begin
            unique case (phase_ff)
               PH_FIRST: begin
                  if (scan_hit) begin
                     idx_ff   <= scan_pos;
                     state_ff <= S_A_MARK;
                  end else begin
                     // wrap to the bottom of the region
                     from_ff  <= '0;
                     to_ff    <= start_ff;
                     p_ff     <= '0;
                     phase_ff <= PH_WRAP;
                     state_ff <= S_SCAN_RD;
                  end
               end
               PH_WRAP: begin
                  priority if (scan_hit) begin
                     idx_ff   <= scan_pos;
                     state_ff <= S_A_MARK;
                  end else if (start_ff == '0) begin
                     // count said free but no clear bit: page zero is taken anyway
                     idx_ff   <= '0;
                     state_ff <= S_A_MARK;
                  end else begin
                     r_ff     <= r_ff + RC_W'(1);
                     state_ff <= S_A_REG;
                  end
               end
               PH_HINT: begin
                  hint_ff[ri] <= scan_hit ? scan_pos : to_ff;
                  state_ff    <= S_RESP;
               end
               default: begin
                  state_ff <= S_IDLE;
               end
            endcase
         end
      end
   end

   // every accepted request leaves idle
   `BPA_ASSERT_NXT(a_accept_busy, req_valid && !req_stall, state_ff != S_IDLE)
   // region 0's used count never exceeds the region size
   `BPA_ASSERT_IMP(a_used_bound, state_ff != S_CLEAR, used_ff[0] <= CNT_W'(REGION_PAGES))
   // both memories written together only by the clearing pass or an alloc
   `BPA_ASSERT_IMP(a_dual_write, bm_we && rc_we, state_ff == S_CLEAR || state_ff == S_A_WR)
   // a finished result reaches the output register once it is free
   `BPA_ASSERT_NXT(a_resp_load, state_ff == S_RESP && (!rsp_valid_ff || !rsp_stall),
                   rsp_valid_ff)

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the bitmap page allocator with reference counts
// depends on bpa_pkg and bitmap_page_allocator_refcount
`timescale 1ns / 1ps

module tb_top;

   localparam int PAGE_SHIFT        = 12;
   localparam int REGION_PAGES      = 4096;
   localparam int COUNT_SLOTS       = 65536;
   localparam int FIRST_UNUSED_KIND = bpa_pkg::KIND_QUERY + 1;
   localparam int WATCHDOG_LIMIT    = 200000;
   localparam int LONG_HOLD         = 400;
   localparam int SETTLE_CYCLES     = 20;
   localparam int QUIET_TAIL        = 200;

   // one predicted response
   typedef struct {
      bpa_pkg::status_type status;
      bit [31:0]         alloc_addr;
      bit signed [7:0]   ref_count;
   } page_result_type;

   // mirror of the allocator state plus the queue of responses still owed
   class page_alloc_scoreboard;
      bit        used_map[2*REGION_PAGES];
      int        used_cnt[2];
      int        hint[2];
      bit [7:0]  refcnt[COUNT_SLOTS];
      bit [31:0] base[2];
      int        pages[2];
      page_result_type owed[$];
      int mismatches;
      int checked;
      int allocs_ok;
      int allocs_refused;

      function void write_reg(bpa_pkg::csr_index_type idx, bit [31:0] value);
         case (idx)
            bpa_pkg::CSR_REGION0_BASE:  base[0]  = value;
            bpa_pkg::CSR_REGION0_PAGES: pages[0] = int'(value[12:0]);
            bpa_pkg::CSR_REGION1_BASE:  base[1]  = value;
            bpa_pkg::CSR_REGION1_PAGES: pages[1] = int'(value[12:0]);
            default: ;
         endcase
      endfunction

      function int eff_pages(int r);
         return pages[r] > REGION_PAGES ? REGION_PAGES : pages[r];
      endfunction

      function int seek_clear(int r, int from, int upto);
         for (int i = from; i < upto; i++)
            if (!used_map[r*REGION_PAGES + i])
               return i;
         return upto;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void note_request(bit [2:0] kind, bit [31:0] addr);
         page_result_type res;
         int n, start, idx, hit;
         bit found;
         bit [31:0] a;
         longint unsigned lo, hi;
         res.status = bpa_pkg::STATUS_OK;
         res.alloc_addr = '0;
         res.ref_count = '0;
         if (kind == bpa_pkg::KIND_ALLOC) begin
            found = 0;
            for (int r = 0; r < 2 && !found; r++) begin
               n = eff_pages(r);
               if (used_cnt[r] >= n) continue;
               start = hint[r] < n ? hint[r] : 0;
               idx = seek_clear(r, start, n);
               if (idx == n) idx = seek_clear(r, 0, start);
               if (idx >= n || (idx == start && start != 0 && used_map[r*REGION_PAGES + idx]))
                  continue;
               used_map[r*REGION_PAGES + idx] = 1;
               used_cnt[r]++;
               hint[r] = seek_clear(r, idx + 1, n);
               a = base[r] + (32'(idx) << PAGE_SHIFT);
               if (a[31:28] == 0) refcnt[a[27:12]] = 1;
               res.alloc_addr = a;
               res.ref_count = 1;
               found = 1;
            end
            if (found) allocs_ok++;
            else begin
               allocs_refused++;
               res.status = bpa_pkg::STATUS_NO_FREE;
               res.alloc_addr = '1;
            end
         end else if (kind == bpa_pkg::KIND_FREE) begin
            if (addr[11:0] != 0) res.status = bpa_pkg::STATUS_MISALGN;
            else if (addr[31:28] != 0) res.status = bpa_pkg::STATUS_RANGE;
            else begin
               found = 0;
               hit = 0;
               for (int r = 0; r < 2 && !found; r++) begin
                  lo = base[r];
                  hi = lo + longint'(eff_pages(r)) * (1 << PAGE_SHIFT);
                  if (addr >= lo && addr < hi) begin
                     found = 1;
                     hit = r;
                  end
               end
               if (!found) res.status = bpa_pkg::STATUS_RANGE;
               else begin
                  refcnt[addr[27:12]] = refcnt[addr[27:12]] - 1;
                  res.ref_count = refcnt[addr[27:12]];
                  if (refcnt[addr[27:12]] != 0) res.status = bpa_pkg::STATUS_STILL;
                  else begin
                     idx = int'((addr - base[hit]) >> PAGE_SHIFT);
                     if (used_map[hit*REGION_PAGES + idx]) begin
                        used_map[hit*REGION_PAGES + idx] = 0;
                        if (used_cnt[hit] > 0) used_cnt[hit]--;
                     end
                     if (idx < hint[hit]) hint[hit] = idx;
                  end
               end
            end
         end else if (kind > bpa_pkg::KIND_QUERY || addr[31:28] != 0) begin
            res.status = bpa_pkg::STATUS_RANGE;
         end else begin
            if (kind == bpa_pkg::KIND_INC)
               refcnt[addr[27:12]] = refcnt[addr[27:12]] + 1;
            else if (kind == bpa_pkg::KIND_DEC)
               refcnt[addr[27:12]] = refcnt[addr[27:12]] - 1;
            res.ref_count = refcnt[addr[27:12]];
         end
         owed.push_back(res);
      endfunction

      function void report(string what);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH %s", what);
      endfunction

      function void check_result(bit [2:0] status, bit [31:0] addr, bit signed [7:0] cnt);
         page_result_type exp;
         if (owed.size() == 0) begin
            report($sformatf("unexpected response status=%0d addr=%h count=%0d",
                             status, addr, cnt));
            return;
         end
         exp = owed.pop_front();
         checked++;
         if (status != exp.status || addr != exp.alloc_addr || cnt != exp.ref_count)
            report($sformatf({"response %0d: expected status=%0d addr=%h count=%0d, ",
                              "got status=%0d addr=%h count=%0d"},
                             checked, exp.status, exp.alloc_addr, exp.ref_count,
                             status, addr, cnt));
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [bpa_pkg::KIND_W-1:0]       req_kind;
   logic [bpa_pkg::ADDR_W-1:0]       req_page_addr;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [bpa_pkg::STATUS_W-1:0]     rsp_status;
   logic [bpa_pkg::ADDR_W-1:0]       rsp_alloc_addr;
   logic signed [bpa_pkg::COUNT_W-1:0] rsp_ref_count;
   logic                             csr_wr_en;
   logic [1:0]                       csr_index;
   logic [bpa_pkg::ADDR_W-1:0]       csr_wdata;

   page_alloc_scoreboard sb = new();

   // idling control shared by both sides
   bit idle_on;
   bit long_hold_req;
   int watchdog;
   int requests_sent;
   int settings_run;

   bitmap_page_allocator_refcount DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_page_addr(req_page_addr),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_alloc_addr(rsp_alloc_addr),
      .rsp_ref_count(rsp_ref_count),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   // response side: random stall bursts, plus one long hold on request
   initial begin
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            rsp_stall <= 1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // response monitor and watchdog; sampled values are pre-edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status, rsp_alloc_addr, rsp_ref_count);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watchdog = 0;
      else watchdog++;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", sb.pending());
         $display("Some tests failed");
         $finish;
      end
   end

   // write all four region registers, one per cycle
   task automatic set_regions(bit [31:0] b0, bit [31:0] p0, bit [31:0] b1, bit [31:0] p1);
      bit [31:0] vals[4];
      vals = '{b0, p0, b1, p1};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(bpa_pkg::csr_index_type'(i), vals[i]);
      end
      csr_wr_en <= 0;
      settings_run++;
   endtask

   // offer one request, wait for acceptance, then maybe leave a gap
   task automatic send_request(bit [2:0] kind, bit [31:0] addr);
      req_valid <= 1;
      req_kind <= kind;
      req_page_addr <= addr;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, addr);
      requests_sent++;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // hold off until every owed response is back
   task automatic drain();
      req_valid <= 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // address mostly inside a configured region, sometimes off page or anywhere
   function automatic bit [31:0] pick_addr();
      int r, n, roll;
      r = $urandom_range(0, 1);
      n = sb.eff_pages(r);
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return sb.base[r] + (32'($urandom_range(0, n + 1)) << PAGE_SHIFT);
      else if (roll < 80)
         return sb.base[r] + (32'($urandom_range(0, n)) << PAGE_SHIFT)
                + $urandom_range(1, 4095);
      else if (roll < 90)
         return $urandom;
      else
         return {4'($urandom_range(0, 15)), 28'($urandom)} & 32'hFFFF_F000;
   endfunction

   task automatic random_requests(int count, bit hold_midway, bit quiet_tail);
      int roll;
      bit [2:0] kind;
      for (int i = 0; i < count; i++) begin
         // alternate stretches with and without idling, none at the very end if quiet_tail is set
         if (quiet_tail && i >= count - QUIET_TAIL) idle_on = 0;
         else idle_on = ((i / 60) % 3) != 2;
         if (hold_midway && i == count / 2) long_hold_req = 1;
         roll = $urandom_range(0, 99);
         if (roll < 35) kind = bpa_pkg::KIND_ALLOC;
         else if (roll < 65) kind = bpa_pkg::KIND_FREE;
         else if (roll < 75) kind = bpa_pkg::KIND_INC;
         else if (roll < 83) kind = bpa_pkg::KIND_DEC;
         else if (roll < 94) kind = bpa_pkg::KIND_QUERY;
         else kind = 3'($urandom_range(FIRST_UNUSED_KIND, 7));
         send_request(kind, pick_addr());
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_kind = '0;
      req_page_addr = '0;
      csr_wr_en = 0;
      csr_index = '0;
      csr_wdata = '0;
      idle_on = 0;
      long_hold_req = 0;
      watchdog = 0;
      requests_sent = 0;
      settings_run = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: two tiny regions, fill them, refuse, then the free paths
      set_regions(32'h0010_0000, 4, 32'h0020_0000, 4);
      idle_on = 1;
      repeat (9) send_request(bpa_pkg::KIND_ALLOC, '0);  // last one finds no page
      send_request(bpa_pkg::KIND_FREE, 32'h0010_0800);    // off page boundary
      send_request(bpa_pkg::KIND_FREE, 32'hFFFF_F000);    // past the count array
      send_request(bpa_pkg::KIND_FREE, 32'h0030_0000);    // in neither region
      send_request(bpa_pkg::KIND_INC, 32'h0010_1000);
      send_request(bpa_pkg::KIND_FREE, 32'h0010_1000);    // still referenced
      send_request(bpa_pkg::KIND_FREE, 32'h0010_1000);    // released, hint drops
      send_request(bpa_pkg::KIND_FREE, 32'h0010_1000);    // bit already clear, count wraps
      send_request(bpa_pkg::KIND_INC, 32'h0010_1000);
      send_request(bpa_pkg::KIND_QUERY, 32'h0010_0000);
      send_request(bpa_pkg::KIND_DEC, 32'h0010_0000);
      send_request(bpa_pkg::KIND_QUERY, 32'h0020_0FFF);   // count ops ignore alignment
      send_request(bpa_pkg::KIND_QUERY, 32'hF000_0000);
      send_request(3'(FIRST_UNUSED_KIND), '0);
      send_request(3'(FIRST_UNUSED_KIND + 1), '1);
      send_request(3'(FIRST_UNUSED_KIND + 2), '0);
      send_request(bpa_pkg::KIND_ALLOC, '0);              // reuses the freed page
      send_request(bpa_pkg::KIND_FREE, 32'hFFFF_FFFF);
      drain();

      random_requests(300, 0, 0);
      drain();

      // long receiver hold to back the block up
      set_regions(32'h0100_0000, 16, 32'h0080_0000, 8);
      random_requests(400, 1, 0);
      drain();

      // empty first region, second straddles the end of the count array
      set_regions(32'h0000_0000, 0, 32'h0FFF_0000, 64);
      random_requests(400, 0, 0);
      drain();

      // oversized count clamps, addresses wrap past the top
      set_regions(32'hFFFF_F000, 13'h1FFF, 32'h0300_0000, REGION_PAGES);
      random_requests(250, 0, 0);
      drain();

      // random small regions, no idling in the closing stretch
      set_regions({16'($urandom_range(0, 16'hFFFF)), 16'h0}, $urandom_range(1, 32),
                  {16'($urandom_range(0, 16'hFFFF)), 16'h0}, $urandom_range(1, 32));
      random_requests(500, 0, 1);
      idle_on = 0;
      drain();

      sb.mismatches += sb.pending();
      $display("ran %0d requests over %0d region settings, %0d responses checked",
               requests_sent, settings_run, sb.checked);
      $display("allocations granted %0d, refused %0d, mismatches %0d",
               sb.allocs_ok, sb.allocs_refused, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
